>>> design/sha1_pkg.sv
// Shared types, constants and round functions for the SHA-1 digest block.
package sha1_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned HASH_WORDS = 5;

    localparam logic [6:0] ROUND_LAST   = 7'd79;
    localparam logic [3:0] SLOT_LAST    = 4'd15;
    localparam logic [3:0] SLOT_LEN_HI  = 4'd14;
    localparam logic [2:0] WORD_IDX_LAST = 3'd4;
    localparam logic [7:0] PAD_BYTE     = 8'h80;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic absorb;       // take message_byte into the current word
        logic push_mark;    // push the partial word closed with the pad byte
        logic push_zero;    // push an all-zero word
        logic push_len_hi;  // push the upper half of the bit length
        logic push_len_lo;  // push the lower half of the bit length
        logic start_comp;   // load working words and clear the round counter
        logic round;        // run one compression round
        logic fold;         // add working words into the chaining words
        logic out_next;     // current digest word was taken
    } sha1_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [3:0] slot;          // words already in the block buffer
        logic       byte_pos_last; // next byte completes the block
        logic       round_last;    // round counter sits at the final round
        logic       out_last;      // digest word on the output is the last one
    } sha1_sts_t;

    function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] res;
        if (rnd inside {[7'd0:7'd19]})
        begin
            res = (b & c) | (~b & d);
        end
        else if (rnd inside {[7'd40:7'd59]})
        begin
            res = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        logic [31:0] res;
        if (rnd inside {[7'd0:7'd19]})
        begin
            res = K_R0;
        end
        else if (rnd inside {[7'd20:7'd39]})
        begin
            res = K_R1;
        end
        else if (rnd inside {[7'd40:7'd59]})
        begin
            res = K_R2;
        end
        else
        begin
            res = K_R3;
        end
        return res;
    endfunction

    // Place a byte into a big-endian word at byte position pos; earlier bytes are kept.
    function automatic logic [31:0] sha1_place(input logic [31:0] acc, input logic [1:0] pos,
                                               input logic [7:0] value);
        logic [31:0] res;
        case (pos)
            2'd0:    res = {value, 24'h000000};
            2'd1:    res = {acc[31:24], value, 16'h0000};
            2'd2:    res = {acc[31:16], value, 8'h00};
            2'd3:    res = {acc[31:8], value};
            default: res = {value, 24'h000000};
        endcase
        return res;
    endfunction

endpackage

>>> design/sha1_in_if.sv
// Message byte channel: valid/ready handshake with byte and end-mark payload.
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output message_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink (input valid, input message_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

>>> design/sha1_out_if.sv
// Digest word channel: valid/ready handshake with word, index and last flag.
interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

>>> design/sha1_datapath.sv
// SHA-1 datapath: byte packing, block window, round unit, chaining words and output.
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha1_cmd_t   cmd,
    input  logic [7:0]  message_byte,
    output sha1_sts_t   sts,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    logic [31:0] h_reg [HASH_WORDS];
    logic [31:0] win_reg [BLK_WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] acc_reg;
    logic [63:0] count_reg;
    logic [3:0]  slot_reg;
    logic [6:0]  round_reg;
    logic [2:0]  idx_reg;

    logic [1:0]  byte_pos;
    logic [31:0] acc_next;
    logic [31:0] mark_word;
    logic [63:0] bit_len;
    logic        push;
    logic [31:0] push_word;
    logic [31:0] sched_x;
    logic [31:0] sched_next;
    logic [31:0] t_next;

    assign byte_pos  = count_reg[1:0];
    assign acc_next  = sha1_place(acc_reg, byte_pos, message_byte);
    assign mark_word = sha1_place(acc_reg, byte_pos, PAD_BYTE);
    assign bit_len   = {count_reg[60:0], 3'b000};

    // A word enters the window when its fourth byte arrives or during padding.
    assign push = (cmd.absorb && (byte_pos == 2'd3)) || cmd.push_mark || cmd.push_zero
                  || cmd.push_len_hi || cmd.push_len_lo;

    always_comb
    begin
        if (cmd.push_mark)
        begin
            push_word = mark_word;
        end
        else if (cmd.push_zero)
        begin
            push_word = '0;
        end
        else if (cmd.push_len_hi)
        begin
            push_word = bit_len[63:32];
        end
        else if (cmd.push_len_lo)
        begin
            push_word = bit_len[31:0];
        end
        else
        begin
            push_word = acc_next;
        end
    end

    // The window always holds the next sixteen schedule words, oldest at entry zero.
    assign sched_x    = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign sched_next = {sched_x[30:0], sched_x[31]};
    assign t_next     = {a_reg[26:0], a_reg[31:27]} + sha1_f(round_reg, b_reg, c_reg, d_reg)
                        + e_reg + sha1_k(round_reg) + win_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
        begin
            acc_reg <= acc_next;
        end
        if (push || cmd.round)
        begin
            for (int i = 0; i < BLK_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[BLK_WORDS - 1] <= push ? push_word : sched_next;
        end
        if (cmd.start_comp)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
            count_reg <= '0;
            slot_reg  <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.absorb)
            begin
                count_reg <= count_reg + 64'd1;
            end
            if (push)
            begin
                slot_reg <= slot_reg + 4'd1;
            end
            if (cmd.start_comp)
            begin
                round_reg <= '0;
            end
            else if (cmd.round)
            begin
                round_reg <= round_reg + 7'd1;
            end
            if (cmd.fold)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            if (cmd.out_next)
            begin
                if (idx_reg == WORD_IDX_LAST)
                begin
                    // Digest delivered: start over for the next message.
                    idx_reg   <= '0;
                    count_reg <= '0;
                    slot_reg  <= '0;
                    for (int i = 0; i < HASH_WORDS; i++)
                    begin
                        h_reg[i] <= H_INIT[i];
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    assign sts.slot          = slot_reg;
    assign sts.byte_pos_last = (count_reg[5:0] == 6'h3F);
    assign sts.round_last    = (round_reg == ROUND_LAST);
    assign sts.out_last      = (idx_reg == WORD_IDX_LAST);

    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = sts.out_last;

endmodule

>>> design/sha1_ctrl.sv
// SHA-1 controller: sequences byte intake, padding, compression and digest output.
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      msg_valid,
    input  logic      byte_present,
    input  logic      end_of_message,
    output logic      msg_ready,
    output logic      digest_valid,
    input  logic      digest_ready,
    input  sha1_sts_t sts,
    output sha1_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_MARK,
        S_ZERO,
        S_LEN_HI,
        S_LEN_LO,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    state_t resume_reg, resume_next;
    logic   extra_reg, extra_next;
    logic   accept;

    assign msg_ready    = (state_reg == S_IDLE);
    assign digest_valid = (state_reg == S_OUT);
    assign accept       = msg_valid && msg_ready;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        resume_next = resume_reg;
        extra_next  = extra_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.absorb = byte_present;
                    if (byte_present && sts.byte_pos_last)
                    begin
                        cmd.start_comp = 1'b1;
                        state_next     = S_ROUND;
                        resume_next    = end_of_message ? S_MARK : S_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (sts.round_last)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = resume_reg;
            end
            S_MARK:
            begin
                cmd.push_mark = 1'b1;
                // No room for the length after the marker: a second block follows.
                extra_next = (sts.slot == SLOT_LEN_HI);
                if (sts.slot == SLOT_LAST)
                begin
                    cmd.start_comp = 1'b1;
                    resume_next    = S_ZERO;
                    state_next     = S_ROUND;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (sts.slot == SLOT_LEN_HI && !extra_reg)
                begin
                    state_next = S_LEN_HI;
                end
                else
                begin
                    cmd.push_zero = 1'b1;
                    if (sts.slot == SLOT_LAST)
                    begin
                        cmd.start_comp = 1'b1;
                        extra_next     = 1'b0;
                        resume_next    = S_ZERO;
                        state_next     = S_ROUND;
                    end
                end
            end
            S_LEN_HI:
            begin
                cmd.push_len_hi = 1'b1;
                state_next      = S_LEN_LO;
            end
            S_LEN_LO:
            begin
                cmd.push_len_lo = 1'b1;
                cmd.start_comp  = 1'b1;
                resume_next     = S_OUT;
                state_next      = S_ROUND;
            end
            S_OUT:
            begin
                if (digest_ready)
                begin
                    cmd.out_next = 1'b1;
                    if (sts.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            resume_reg <= S_IDLE;
            extra_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            extra_reg  <= extra_next;
        end
    end

`ifndef SYNTH
    a_comp_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_comp |-> (sts.slot == SLOT_LAST))
        else $error("compression started on a partly filled block");

    a_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (sts.slot == 4'd0))
        else $error("digest offered while block buffer holds words");

    a_len_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN_HI) |-> (sts.slot == SLOT_LEN_HI))
        else $error("length words misplaced in the final block");

    a_extra_blk: assert property (@(posedge clk) disable iff (!rst_n)
        extra_reg |-> (state_reg == S_ZERO && sts.slot == SLOT_LAST))
        else $error("second padding block flag out of step");
`endif

endmodule

>>> design/sha1_message_digest_top.sv
// Top level of the byte-serial SHA-1 message digest block.
//
// The block hashes a message that arrives one byte per item on the msg channel
// and returns the 160-bit digest as five 32-bit items on the digest channel,
// word 0 first, with last_word set on word 4. An item with byte_present low
// carries no byte; if it also has end_of_message set it ends the message, which
// allows an empty message. Every 64th byte completes a block, and no item is
// accepted while that block is compressed: 80 rounds on the single round unit,
// then the addition of the result into the chaining words. The end-of-message
// item starts padding: the marker word, zero words and the two length words
// (between 3 and 18 padding words in all), with one or two further compressions,
// and then the five digest words, one per cycle while the sink is ready. The
// block then holds its initial chaining values again and takes the next message.
// Work on one message ends before the next item is accepted; the controller
// state machine in sha1_ctrl sequences these steps and sha1_datapath holds the
// block window, round logic and chaining words.
module sha1_message_digest_top
    import sha1_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sha1_in_if.sink      msg,
    sha1_out_if.source   digest
);

    sha1_cmd_t cmd;
    sha1_sts_t sts;

    sha1_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg.valid),
        .byte_present   (msg.byte_present),
        .end_of_message (msg.end_of_message),
        .msg_ready      (msg.ready),
        .digest_valid   (digest.valid),
        .digest_ready   (digest.ready),
        .sts            (sts),
        .cmd            (cmd)
    );

    sha1_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_byte (msg.message_byte),
        .sts          (sts),
        .digest_word  (digest.digest_word),
        .word_index   (digest.word_index),
        .last_word    (digest.last_word)
    );

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the byte-serial SHA-1 message digest block.
module testbench;
    import sha1_pkg::*;

    // Longest stretch without any handshake that a correct run can show: two
    // compressions plus padding, the receiver hold-off and idle gaps, taken
    // several times over.
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 300;
    localparam int DIRECTED_N   = 13;

    localparam logic [31:0] ROUND_K0 = 32'h5A827999;
    localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;
    localparam logic [7:0]  MARK_BYTE = 8'h80;

    // Published digests of the empty message and of "abc".
    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         eom;
        logic         known;        // digest is typed in below, not predicted
        logic [159:0] known_digest;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    logic clk = 1'b0;
    logic rst_n;

    sha1_in_if  msg_if ();
    sha1_out_if digest_if ();

    sha1_message_digest_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (digest_if)
    );

    always #5 clk = ~clk;

    // Directed items. Rows with the known flag carry a digest that can be
    // checked against published values; all other rows go through the
    // predictor below.
    msg_item_t directed_rows [DIRECTED_N] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // empty message
        '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},         // neither byte nor end mark
        '{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},         // byte without its present flag
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},     // "abc"
        '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},         // single all-ones byte
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},         // single zero byte
        '{8'h55, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h5a, 1'b0, 1'b0, 1'b0, 160'h0},         // ignored item inside a message
        '{8'haa, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hc3, 1'b0, 1'b1, 1'b0, 160'h0},         // end mark without a byte
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}    // empty again after a restart
    };

    int boundary_lens [10] = '{0, 55, 56, 57, 63, 64, 65, 119, 120, 128};

    msg_item_t    stim_q [$];
    digest_item_t pending_digest_words [$];

    // Predictor state: chaining words, block window and message byte count.
    logic [31:0] chain_q [5];
    logic [31:0] block_q [16];
    logic [63:0] byte_count;

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int words_taken    = 0;
    int random_items   = 0;
    int send_quiet     = 0;
    int recv_quiet     = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_restart();
        chain_q[0] = 32'h67452301;
        chain_q[1] = 32'hEFCDAB89;
        chain_q[2] = 32'h98BADCFE;
        chain_q[3] = 32'h10325476;
        chain_q[4] = 32'hC3D2E1F0;
        byte_count = 64'd0;
    endfunction

    // Eighty rounds over the block window, then add into the chaining words.
    function automatic void sha1_fold_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, x, wr;
        w = block_q;
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        e = chain_q[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
            begin
                wr = w[r];
            end
            else
            begin
                x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
                wr = rotl32(x, 1);
                w[r % 16] = wr;
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = ROUND_K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = ROUND_K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = ROUND_K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = ROUND_K3;
            end
            t = rotl32(a, 5) + f + e + k + wr;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain_q[0] += a;
        chain_q[1] += b;
        chain_q[2] += c;
        chain_q[3] += d;
        chain_q[4] += e;
    endfunction

    // Big-endian byte placement; the first byte of a word clears the rest of it.
    function automatic void put_byte(input logic [5:0] pos, input logic [7:0] value);
        if (pos[1:0] == 2'd0)
        begin
            block_q[pos[5:2]] = {value, 24'h0};
        end
        else
        begin
            block_q[pos[5:2]] |= 32'(value) << ((3 - pos[1:0]) * 8);
        end
    endfunction

    function automatic void sha1_take_byte(input logic [7:0] value);
        put_byte(byte_count[5:0], value);
        byte_count++;
        if (byte_count[5:0] == 6'd0)
        begin
            sha1_fold_block();
        end
    endfunction

    // Mark byte, zero fill and 64-bit bit length; a second block is needed
    // when the mark lands in the last eight bytes of the window.
    function automatic void sha1_close_message();
        logic [5:0]  pos;
        logic [63:0] bit_len;
        pos = byte_count[5:0];
        bit_len = byte_count << 3;
        put_byte(pos, MARK_BYTE);
        for (int i = int'(pos[5:2]) + 1; i < 16; i++)
        begin
            block_q[i] = 32'h0;
        end
        if (pos >= 6'd56)
        begin
            sha1_fold_block();
            for (int i = 0; i < 16; i++)
            begin
                block_q[i] = 32'h0;
            end
        end
        block_q[14] = bit_len[63:32];
        block_q[15] = bit_len[31:0];
        sha1_fold_block();
    endfunction

    // Called once per accepted item; queues the five words an end mark causes.
    function automatic void digest_of_item(input msg_item_t it);
        digest_item_t d;
        if (it.present)
        begin
            sha1_take_byte(it.data);
        end
        if (it.eom)
        begin
            sha1_close_message();
            for (int i = 0; i < 5; i++)
            begin
                d.word = it.known ? it.known_digest[159 - 32 * i -: 32] : chain_q[i];
                d.index = 3'(i);
                d.last = (i == 4);
                pending_digest_words.push_back(d);
            end
            sha1_restart();
        end
    endfunction

    // Random idle gap, with occasional runs of back-to-back items.
    function automatic int draw_gap(inout int quiet_left);
        int gap;
        if (quiet_left > 0)
        begin
            quiet_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            quiet_left = $urandom_range(10, 40);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 6);
        end
        return gap;
    endfunction

    function automatic void push_item(input logic [7:0] data, input logic present,
                                      input logic eom);
        msg_item_t it;
        it = '{data, present, eom, 1'b0, 160'h0};
        stim_q.push_back(it);
        if (present || eom)
        begin
            random_items++;
        end
    endfunction

    // One message of random bytes, with ignored items sprinkled in; the end
    // mark rides on the last byte or comes as an item of its own.
    function automatic void add_random_message(input int len);
        logic end_alone;
        end_alone = (len == 0) || ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_item(8'($urandom), 1'b0, 1'b0);
            end
            push_item(8'($urandom), 1'b1, (i == len - 1) && !end_alone);
        end
        if (end_alone)
        begin
            push_item(8'($urandom), 1'b0, 1'b1);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Watchdog: any cycle without a handshake on either channel counts.
    always @(posedge clk)
    begin
        if ((msg_if.valid && msg_if.ready) || (digest_if.valid && digest_if.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("testbench failed");
        $finish;
    end

    // Sender: builds the item list, then offers each item after a random gap
    // and runs the predictor on every item that the block accepts.
    initial
    begin
        int gap;
        msg_if.valid          <= 1'b0;
        msg_if.message_byte   <= 8'h00;
        msg_if.byte_present   <= 1'b0;
        msg_if.end_of_message <= 1'b0;
        rst_n                 <= 1'b0;
        sha1_restart();

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            stim_q.push_back(directed_rows[i]);
        end
        // Lengths around the padding boundaries come first, then mostly short
        // messages with an occasional boundary length.
        add_random_message(55);
        add_random_message(56);
        add_random_message(64);
        while (random_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                add_random_message(boundary_lens[$urandom_range(0, 9)]);
            end
            else
            begin
                add_random_message($urandom_range(0, 40));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_q[n])
        begin
            gap = draw_gap(send_quiet);
            if (gap > 0)
            begin
                msg_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            msg_if.valid          <= 1'b1;
            msg_if.message_byte   <= stim_q[n].data;
            msg_if.byte_present   <= stim_q[n].present;
            msg_if.end_of_message <= stim_q[n].eom;
            do
                @(posedge clk);
            while (!(msg_if.valid && msg_if.ready));
            digest_of_item(stim_q[n]);
        end
        msg_if.valid <= 1'b0;

        while (pending_digest_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

    // Receiver: random ready gaps, plus two long hold-offs during which the
    // sender keeps offering items and the block has to stall its input.
    initial
    begin
        int gap;
        digest_item_t want;
        digest_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (words_taken == 7 || words_taken == 33)
            begin
                gap = HOLD_CYCLES;
            end
            else
            begin
                gap = draw_gap(recv_quiet);
            end
            if (gap > 0)
            begin
                digest_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            digest_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(digest_if.valid && digest_if.ready));

            if (pending_digest_words.size() == 0)
            begin
                report_mismatch("unexpected digest_word", digest_if.digest_word, 32'h0);
            end
            else
            begin
                want = pending_digest_words.pop_front();
                if (digest_if.digest_word !== want.word)
                begin
                    report_mismatch("digest_word", digest_if.digest_word, want.word);
                end
                if (digest_if.word_index !== want.index)
                begin
                    report_mismatch("word_index", 32'(digest_if.word_index), 32'(want.index));
                end
                if (digest_if.last_word !== want.last)
                begin
                    report_mismatch("last_word", 32'(digest_if.last_word), 32'(want.last));
                end
            end
            words_taken++;
        end
    end

endmodule
